// ===== design/frame_difference_mean_mask_unit_defines.svh =====
// Assertion macros shared by the frame difference mask unit.
// Each macro expects clk and rst_n in the using scope.
`ifndef FRAME_DIFFERENCE_MEAN_MASK_UNIT_DEFINES_SVH
`define FRAME_DIFFERENCE_MEAN_MASK_UNIT_DEFINES_SVH

// Same-cycle implication
`define FDMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FDMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fdmm_pkg.sv =====
`timescale 1ns / 1ps

package fdmm_pkg;

    // Field widths
    localparam int OP_W       = 2;
    localparam int COORD_W    = 9;
    localparam int CHROMA_W   = 8;
    localparam int DIM_W      = 10;
    localparam int THR_W      = 13;
    localparam int THR_SQ_W   = 2 * THR_W;
    localparam int SUM_W      = 33;
    localparam int DIST_W     = 17;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Reset values of the size registers
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(512);

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FRAMES = 2'd1,
        ST_BAD_COORD = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_THRESHOLD    = 2'd2
    } cfg_index_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
        logic [THR_SQ_W-1:0] thr_sq;
        logic                thr_changed;
    } cfg_t;

endpackage

// ===== design/fdmm_mem.sv =====
`timescale 1ns / 1ps

module fdmm_mem #(
    parameter int AW = 18,
    parameter int DW = 49
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem_array [2**AW];
    logic [DW-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/fdmm_cfg.sv =====
`timescale 1ns / 1ps

module fdmm_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fdmm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fdmm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output fdmm_pkg::cfg_t                   cfg
);

    import fdmm_pkg::*;

    logic [DIM_W-1:0]    frame_width_reg;
    logic [DIM_W-1:0]    frame_width_next;
    logic [DIM_W-1:0]    frame_height_reg;
    logic [DIM_W-1:0]    frame_height_next;
    logic [THR_SQ_W-1:0] thr_sq_reg;
    logic [THR_SQ_W-1:0] thr_sq_next;
    logic                thr_changed_reg;
    logic                thr_changed_next;

    assign cfg_ready = 1'b1;

    // Register decode; threshold is kept squared
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        thr_sq_next       = thr_sq_reg;
        thr_changed_next  = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_next  = cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_next = cfg_data[DIM_W-1:0];
                CFG_THRESHOLD:
                begin
                    thr_sq_next      = THR_SQ_W'(cfg_data) * THR_SQ_W'(cfg_data);
                    thr_changed_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_RESET;
            frame_height_reg <= DIM_RESET;
            thr_sq_reg       <= '0;
            thr_changed_reg  <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            thr_sq_reg       <= thr_sq_next;
            thr_changed_reg  <= thr_changed_next;
        end
    end

    assign cfg.frame_width  = frame_width_reg;
    assign cfg.frame_height = frame_height_reg;
    assign cfg.thr_sq       = thr_sq_reg;
    assign cfg.thr_changed  = thr_changed_reg;

endmodule

// ===== design/fdmm_core.sv =====
`timescale 1ns / 1ps
`include "frame_difference_mean_mask_unit_defines.svh"

module fdmm_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int COUNT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fdmm_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fdmm_pkg::OP_W-1:0]       opcode,
    input  logic [fdmm_pkg::COORD_W-1:0]    pos_x,
    input  logic [fdmm_pkg::COORD_W-1:0]    pos_y,
    input  logic [fdmm_pkg::CHROMA_W-1:0]   chroma_u,
    input  logic [fdmm_pkg::CHROMA_W-1:0]   chroma_v,
    input  logic                            frame_end,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [fdmm_pkg::STATUS_W-1:0]   status,
    output logic                            mask_white
);

    import fdmm_pkg::*;

    // Address bits per axis; coordinates only reach 9 bits
    localparam int XB = (MAX_WIDTH >= (1 << COORD_W)) ? COORD_W :
                        ((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1);
    localparam int YB = (MAX_HEIGHT >= (1 << COORD_W)) ? COORD_W :
                        ((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1);
    localparam int AW    = XB + YB;
    localparam int DW    = 2 * CHROMA_W + SUM_W;
    localparam int RW    = THR_SQ_W + COUNT_BITS;
    localparam int LHS_W = SUM_W + 8;
    localparam int CMP_W = (RW > LHS_W) ? RW : LHS_W;
    localparam int LIM_W = 13;
    localparam logic [LIM_W-1:0] MAX_W_LIM = LIM_W'(MAX_WIDTH);
    localparam logic [LIM_W-1:0] MAX_H_LIM = LIM_W'(MAX_HEIGHT);

    // Stage 0: accept and read
    logic          in_accept;
    logic [AW-1:0] in_addr;
    logic          coord_ok;

    // Stage 1 registers
    logic                s1_valid_reg;
    logic                s1_valid_next;
    opcode_t             s1_op_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [CHROMA_W-1:0] s1_u_reg;
    logic [CHROMA_W-1:0] s1_v_reg;
    logic                s1_last_reg;
    logic                s1_ok_reg;
    logic                s1_adv;

    // Forwarding of the write that coincided with the read
    logic          fwd_hit_reg;
    logic [DW-1:0] fwd_data_reg;

    // Memory port
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [DW-1:0] mem_wr_data;
    logic [DW-1:0] mem_rd_data;

    // Stage 1 datapath
    logic [DW-1:0]        cur_word;
    logic [CHROMA_W-1:0]  cur_u;
    logic [CHROMA_W-1:0]  cur_v;
    logic [SUM_W-1:0]     cur_sum;
    logic signed [8:0]    du;
    logic signed [8:0]    dv;
    logic signed [17:0]   du_sq;
    logic signed [17:0]   dv_sq;
    logic [DIST_W-1:0]    dist_sq;
    logic [SUM_W:0]       sum_wide;
    logic [SUM_W-1:0]     sum_new;
    logic                 is_add;
    logic                 fd_sat;
    logic                 item_we;
    logic [DW-1:0]        item_wdata;
    logic [CMP_W-1:0]     lhs;
    logic [CMP_W-1:0]     rhs;
    status_t              res_status;
    logic                 res_white;

    // Frame statistics
    logic                  have_ref_reg;
    logic                  have_ref_next;
    logic [COUNT_BITS-1:0] fd_reg;
    logic [COUNT_BITS-1:0] fd_next;
    logic [RW-1:0]         rhs_reg;
    logic [RW-1:0]         rhs_next;
    logic [RW-1:0]         rhs_prod;

    // Clearing pass
    logic          clr_active_reg;
    logic          clr_active_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    // Output register
    logic    out_valid_reg;
    logic    out_valid_next;
    status_t status_reg;
    logic    mask_white_reg;

    // Handshake and coordinate check
    assign in_addr  = {pos_y[YB-1:0], pos_x[XB-1:0]};
    assign coord_ok = ({1'b0, pos_x} < cfg.frame_width) &&
                      ({1'b0, pos_y} < cfg.frame_height) &&
                      (LIM_W'(pos_x) < MAX_W_LIM) &&
                      (LIM_W'(pos_y) < MAX_H_LIM);
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = clr_active_reg ||
                       (s1_valid_reg && (!s1_adv || (s1_op_reg == OP_CLEAR)));
    assign in_accept = in_valid && !in_stall;

    fdmm_mem #(
        .AW (AW),
        .DW (DW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (in_accept),
        .rd_addr (in_addr),
        .rd_data (mem_rd_data)
    );

    // Stage 1 word with forwarding
    assign cur_word = fwd_hit_reg ? fwd_data_reg : mem_rd_data;
    assign cur_u    = cur_word[DW-1 -: CHROMA_W];
    assign cur_v    = cur_word[SUM_W +: CHROMA_W];
    assign cur_sum  = cur_word[SUM_W-1:0];

    // Squared chroma distance and saturating accumulate
    assign du       = $signed({1'b0, s1_u_reg}) - $signed({1'b0, cur_u});
    assign dv       = $signed({1'b0, s1_v_reg}) - $signed({1'b0, cur_v});
    assign du_sq    = du * du;
    assign dv_sq    = dv * dv;
    assign dist_sq  = DIST_W'(du_sq[15:0]) + DIST_W'(dv_sq[15:0]);
    assign sum_wide = {1'b0, cur_sum} + (SUM_W + 1)'(dist_sq);
    assign sum_new  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    // Write-back decision
    assign is_add     = (s1_op_reg == OP_ADD) && s1_ok_reg;
    assign fd_sat     = &fd_reg;
    assign item_we    = s1_adv && is_add && (!have_ref_reg || !fd_sat);
    assign item_wdata = {s1_u_reg, s1_v_reg, (have_ref_reg ? sum_new : cur_sum)};

    assign mem_wr_en   = clr_active_reg || item_we;
    assign mem_wr_addr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_wr_data = clr_active_reg ? '0 : item_wdata;

    // Query compare: 256*acc > t^2*n
    assign lhs = CMP_W'({cur_sum, 8'b0});
    assign rhs = CMP_W'(rhs_reg);

    always_comb
    begin
        res_status = ST_OK;
        res_white  = 1'b0;
        case (s1_op_reg) inside
            OP_ADD, OP_QUERY:
            begin
                if (!s1_ok_reg)
                begin
                    res_status = ST_BAD_COORD;
                end
                else if (s1_op_reg == OP_QUERY)
                begin
                    if (fd_reg == '0)
                    begin
                        res_status = ST_NO_FRAMES;
                    end
                    else
                    begin
                        res_white = (lhs > rhs);
                    end
                end
            end
            default: ;
        endcase
    end

    // Frame statistics; rhs_reg tracks t^2 * frames_done
    assign rhs_prod = cfg.thr_sq * fd_reg;

    always_comb
    begin
        have_ref_next = have_ref_reg;
        fd_next       = fd_reg;
        rhs_next      = rhs_reg;
        if (cfg.thr_changed)
        begin
            rhs_next = rhs_prod;
        end
        if (s1_adv)
        begin
            if (is_add && s1_last_reg)
            begin
                if (!have_ref_reg)
                begin
                    have_ref_next = 1'b1;
                end
                else if (!fd_sat)
                begin
                    fd_next  = fd_reg + COUNT_BITS'(1);
                    rhs_next = rhs_reg + RW'(cfg.thr_sq);
                end
            end
            else if (s1_op_reg == OP_CLEAR)
            begin
                have_ref_next = 1'b0;
                fd_next       = '0;
                rhs_next      = '0;
            end
        end
    end

    // Clearing pass sequencer
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (&clr_addr_reg)
            begin
                clr_active_next = 1'b0;
            end
        end
        if (s1_adv && (s1_op_reg == OP_CLEAR))
        begin
            clr_active_next = 1'b1;
            clr_addr_next   = '0;
        end
    end

    assign s1_valid_next  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (out_valid_reg && out_stall);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            have_ref_reg   <= 1'b0;
            fd_reg         <= '0;
            rhs_reg        <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            have_ref_reg   <= have_ref_next;
            fd_reg         <= fd_next;
            rhs_reg        <= rhs_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            out_valid_reg  <= out_valid_next;
            if (in_accept)
            begin
                fwd_hit_reg <= item_we && (s1_addr_reg == in_addr);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg    <= opcode_t'(opcode);
            s1_addr_reg  <= in_addr;
            s1_u_reg     <= chroma_u;
            s1_v_reg     <= chroma_v;
            s1_last_reg  <= frame_end;
            s1_ok_reg    <= coord_ok;
            fwd_data_reg <= item_wdata;
        end
        if (s1_adv)
        begin
            status_reg     <= res_status;
            mask_white_reg <= res_white;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign mask_white = mask_white_reg;

    // Checks
    `FDMM_ASSERT_NOW(a_no_accept_in_clear, clr_active_reg, in_stall, "item taken during clear")
    `FDMM_ASSERT_NOW(a_no_item_write_in_clear, clr_active_reg, !item_we, "write during clear")
    `FDMM_ASSERT_NOW(a_count_needs_ref, fd_reg != '0, have_ref_reg, "frames without reference")
    `FDMM_ASSERT_NOW(a_rhs_zero, !cfg.thr_changed && fd_reg == '0, rhs_reg == '0, "rhs not zero")
    `FDMM_ASSERT_NEXT(a_clear_starts, s1_adv && s1_op_reg == OP_CLEAR, clr_active_reg && clr_addr_reg == '0, "clear pass not started")

endmodule

// ===== design/frame_difference_mean_mask_unit.sv =====
`timescale 1ns / 1ps
// Channel | Handshake               | Payload
// --------+-------------------------+---------------------------------------------
// input   | in_valid / in_stall     | opcode pos_x pos_y chroma_u chroma_v frame_end
// output  | out_valid / out_stall   | status mask_white
// config  | cfg_valid / cfg_ready   | cfg_index cfg_data
//
// One item per cycle sustained unless in_stall is high; the pixel memory is read at
// the accepting edge, the update stage runs in the next cycle, then the result sits
// in the output register. out_valid rises when that register is loaded.
// Reset and every clear item start a clearing pass over all 2^(XB+YB) words
// (262144 at 512x512), during which in_stall is high, as it is while a clear item
// sits in the update stage; config writes are taken as usual.
// out_stall backs up the update stage, which then holds off new items.

module frame_difference_mean_mask_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int COUNT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fdmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fdmm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fdmm_pkg::OP_W-1:0]       opcode,
    input  logic [fdmm_pkg::COORD_W-1:0]    pos_x,
    input  logic [fdmm_pkg::COORD_W-1:0]    pos_y,
    input  logic [fdmm_pkg::CHROMA_W-1:0]   chroma_u,
    input  logic [fdmm_pkg::CHROMA_W-1:0]   chroma_v,
    input  logic                            frame_end,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [fdmm_pkg::STATUS_W-1:0]   status,
    output logic                            mask_white
);

    import fdmm_pkg::*;

    cfg_t cfg;

    fdmm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fdmm_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .chroma_u   (chroma_u),
        .chroma_v   (chroma_v),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .mask_white (mask_white)
    );

endmodule
